[design/mfm_tfg_pkg.sv]
// Package with the layout constants, register indexes and CRC step of the MFM track generator.
`default_nettype none

package mfm_tfg_pkg;

    localparam int TRACK_BYTES_DEFAULT = 6400;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_SECTORS_PER_TRACK = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAP2_FILL_BYTE    = 1'd1;

    localparam logic [4:0] SECTORS_RESET = 5'd17;
    localparam logic [7:0] GAP2_RESET    = 8'h4E;
    localparam logic [4:0] SECTORS_MIN   = 5'd15;
    localparam logic [4:0] SECTORS_MAX   = 5'd18;

    localparam int LEAD_NORMAL = 60;
    localparam int TAIL_NORMAL = 38;
    localparam int TAIL_DENSE  = 34;
    localparam logic [8:0] SECTOR_BASE_LEN = 9'd318;
    localparam logic [8:0] SECTOR_MAX_LEN  = 9'd356;

    localparam logic [8:0] P_ID_SYNC    = 9'd12;
    localparam logic [8:0] P_ID_MARK    = 9'd15;
    localparam logic [8:0] P_ID_TRACK   = 9'd16;
    localparam logic [8:0] P_ID_SIDE    = 9'd17;
    localparam logic [8:0] P_ID_SECTOR  = 9'd18;
    localparam logic [8:0] P_ID_SIZE    = 9'd19;
    localparam logic [8:0] P_ID_CRC_HI  = 9'd20;
    localparam logic [8:0] P_ID_CRC_LO  = 9'd21;
    localparam logic [8:0] P_GAP2_END   = 9'd44;
    localparam logic [8:0] P_DAT_SYNC   = 9'd56;
    localparam logic [8:0] P_DAT_MARK   = 9'd59;
    localparam logic [8:0] P_DAT_END    = 9'd316;
    localparam logic [8:0] P_DAT_CRC_LO = 9'd317;

    localparam logic [7:0] BYTE_ZERO     = 8'h00;
    localparam logic [7:0] BYTE_GAP      = 8'h4E;
    localparam logic [7:0] BYTE_SYNC     = 8'hA1;
    localparam logic [7:0] BYTE_ID_MARK  = 8'hFE;
    localparam logic [7:0] BYTE_DAT_MARK = 8'hFB;
    localparam logic [7:0] BYTE_SIZE_256 = 8'h01;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // CRC-16-CCITT over one byte, most significant bit first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

[design/mfm_track_format_generator.sv]
// Top level of the MFM track format generator with CRC-16-CCITT ID and data fields.
//
//  channel  | direction | ports
//  ---------+-----------+------------------------------------------------------
//  input    | in        | s_valid, s_ready, s_track_number, s_side_number, s_data_byte
//  result   | out       | m_valid, m_ready, m_track_byte, m_took_data, m_end_of_track
//  config   | in        | cfg_wr_en, cfg_index, cfg_wdata
//
// Each input transfer yields one registered result; one per cycle unless the result stalls.
// The track position, sector counters and CRC advance in the same cycle as the transfer,
// and the byte lands in the output register.
// A stalled result holds the output register; a new transfer is taken as soon as the
// downstream side takes the waiting result.
// Reset (synchronous, active low) restores the registers to 17 sectors and 0x4E gap2 fill.
`default_nettype none

module mfm_track_format_generator #(
    parameter int TRACK_BYTES = mfm_tfg_pkg::TRACK_BYTES_DEFAULT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [mfm_tfg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [mfm_tfg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [7:0]                          s_track_number,
    input  wire logic                                s_side_number,
    input  wire logic [7:0]                          s_data_byte,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [7:0]                               m_track_byte,
    output logic                                     m_took_data,
    output logic                                     m_end_of_track
);

    localparam int POS_W = $clog2(TRACK_BYTES);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(TRACK_BYTES - 1);

    logic [4:0]       sectors_reg;
    logic [7:0]       gap2_fill_reg;
    logic [POS_W-1:0] track_pos_reg;
    logic [POS_W-1:0] track_pos_next;
    logic [4:0]       sector_idx_reg;
    logic [4:0]       sector_idx_next;
    logic [8:0]       sector_pos_reg;
    logic [8:0]       sector_pos_next;
    logic [15:0]      crc_reg;
    logic [15:0]      crc_next;
    logic             m_valid_reg;
    logic [7:0]       track_byte_reg;
    logic [7:0]       track_byte_next;
    logic             took_data_reg;
    logic             took_data_next;
    logic             eot_reg;
    logic             eot_next;
    logic             accept;

    assign s_ready        = !m_valid_reg || m_ready;
    assign accept         = s_valid && s_ready;
    assign m_valid        = m_valid_reg;
    assign m_track_byte   = track_byte_reg;
    assign m_took_data    = took_data_reg;
    assign m_end_of_track = eot_reg;

    always_comb begin
        logic [4:0]       n;
        logic [POS_W-1:0] lead;
        logic [8:0]       slen;
        logic [8:0]       p;
        logic [15:0]      crc_base;
        logic             crc_in;
        n = sectors_reg;
        if (n < mfm_tfg_pkg::SECTORS_MIN) begin
            n = mfm_tfg_pkg::SECTORS_MIN;
        end
        if (n > mfm_tfg_pkg::SECTORS_MAX) begin
            n = mfm_tfg_pkg::SECTORS_MAX;
        end
        lead = (n == mfm_tfg_pkg::SECTORS_MAX) ? '0 : POS_W'(mfm_tfg_pkg::LEAD_NORMAL);
        slen = mfm_tfg_pkg::SECTOR_BASE_LEN + ((n == mfm_tfg_pkg::SECTORS_MAX) ?
               9'(mfm_tfg_pkg::TAIL_DENSE) : 9'(mfm_tfg_pkg::TAIL_NORMAL));
        p = sector_pos_reg;
        crc_base        = crc_reg;
        crc_in          = 1'b0;
        track_byte_next = mfm_tfg_pkg::BYTE_GAP;
        took_data_next  = 1'b0;
        sector_idx_next = sector_idx_reg;
        sector_pos_next = sector_pos_reg;

        if (track_pos_reg >= lead && sector_idx_reg < n) begin
            if (p < mfm_tfg_pkg::P_ID_SYNC) begin
                track_byte_next = mfm_tfg_pkg::BYTE_ZERO;
            end else if (p < mfm_tfg_pkg::P_ID_MARK) begin
                track_byte_next = mfm_tfg_pkg::BYTE_SYNC;
                crc_in = 1'b1;
                if (p == mfm_tfg_pkg::P_ID_SYNC) begin
                    crc_base = mfm_tfg_pkg::CRC_INIT;
                end
            end else if (p == mfm_tfg_pkg::P_ID_MARK) begin
                track_byte_next = mfm_tfg_pkg::BYTE_ID_MARK;
                crc_in = 1'b1;
            end else if (p == mfm_tfg_pkg::P_ID_TRACK) begin
                track_byte_next = s_track_number;
                crc_in = 1'b1;
            end else if (p == mfm_tfg_pkg::P_ID_SIDE) begin
                track_byte_next = {7'd0, s_side_number};
                crc_in = 1'b1;
            end else if (p == mfm_tfg_pkg::P_ID_SECTOR) begin
                track_byte_next = {3'd0, sector_idx_reg} + 8'd1;
                crc_in = 1'b1;
            end else if (p == mfm_tfg_pkg::P_ID_SIZE) begin
                track_byte_next = mfm_tfg_pkg::BYTE_SIZE_256;
                crc_in = 1'b1;
            end else if (p == mfm_tfg_pkg::P_ID_CRC_HI) begin
                track_byte_next = crc_reg[15:8];
            end else if (p == mfm_tfg_pkg::P_ID_CRC_LO) begin
                track_byte_next = crc_reg[7:0];
            end else if (p < mfm_tfg_pkg::P_GAP2_END) begin
                track_byte_next = gap2_fill_reg;
            end else if (p < mfm_tfg_pkg::P_DAT_SYNC) begin
                track_byte_next = mfm_tfg_pkg::BYTE_ZERO;
            end else if (p < mfm_tfg_pkg::P_DAT_MARK) begin
                track_byte_next = mfm_tfg_pkg::BYTE_SYNC;
                crc_in = 1'b1;
                if (p == mfm_tfg_pkg::P_DAT_SYNC) begin
                    crc_base = mfm_tfg_pkg::CRC_INIT;
                end
            end else if (p == mfm_tfg_pkg::P_DAT_MARK) begin
                track_byte_next = mfm_tfg_pkg::BYTE_DAT_MARK;
                crc_in = 1'b1;
            end else if (p < mfm_tfg_pkg::P_DAT_END) begin
                track_byte_next = s_data_byte;
                took_data_next  = 1'b1;
                crc_in = 1'b1;
            end else if (p == mfm_tfg_pkg::P_DAT_END) begin
                track_byte_next = crc_reg[15:8];
            end else if (p == mfm_tfg_pkg::P_DAT_CRC_LO) begin
                track_byte_next = crc_reg[7:0];
            end else begin
                track_byte_next = mfm_tfg_pkg::BYTE_GAP;
            end

            if (p + 9'd1 >= slen) begin
                sector_pos_next = '0;
                sector_idx_next = sector_idx_reg + 5'd1;
            end else begin
                sector_pos_next = p + 9'd1;
            end
        end

        crc_next = crc_in ? mfm_tfg_pkg::crc_byte(crc_base, track_byte_next) : crc_base;

        eot_next = (track_pos_reg >= LAST_POS);
        if (eot_next) begin
            track_pos_next  = '0;
            sector_idx_next = '0;
            sector_pos_next = '0;
            crc_next        = mfm_tfg_pkg::CRC_INIT;
        end else begin
            track_pos_next = track_pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sectors_reg    <= mfm_tfg_pkg::SECTORS_RESET;
            gap2_fill_reg  <= mfm_tfg_pkg::GAP2_RESET;
            track_pos_reg  <= '0;
            sector_idx_reg <= '0;
            sector_pos_reg <= '0;
            crc_reg        <= mfm_tfg_pkg::CRC_INIT;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    mfm_tfg_pkg::REG_SECTORS_PER_TRACK: sectors_reg <= cfg_wdata[4:0];
                    mfm_tfg_pkg::REG_GAP2_FILL_BYTE:    gap2_fill_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (accept) begin
                track_pos_reg  <= track_pos_next;
                sector_idx_reg <= sector_idx_next;
                sector_pos_reg <= sector_pos_next;
                crc_reg        <= crc_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            track_byte_reg <= track_byte_next;
            took_data_reg  <= took_data_next;
            eot_reg        <= eot_next;
        end
    end

    // The last byte of a track rewinds every counter and the CRC.
    a_track_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && track_pos_reg == LAST_POS) |=>
        (track_pos_reg == '0 && sector_idx_reg == '0 && sector_pos_reg == '0 &&
         crc_reg == mfm_tfg_pkg::CRC_INIT && eot_reg))
        else $error("track wrap did not rewind the state");

    a_sector_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sector_pos_reg < mfm_tfg_pkg::SECTOR_MAX_LEN)
        else $error("position in sector beyond the longest sector");

    a_sector_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sector_idx_reg <= mfm_tfg_pkg::SECTORS_MAX)
        else $error("sector index beyond the largest sector count");

    a_payload_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (m_took_data == ($past(sector_pos_reg) > mfm_tfg_pkg::P_DAT_MARK &&
                    $past(sector_pos_reg) < mfm_tfg_pkg::P_DAT_END) || !m_took_data))
        else $error("payload flag outside the data field");

endmodule

`default_nettype wire
